@@ src/assert_macros.svh @@
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ASSERT_PROP(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

@@ src/tscd_pkg.sv @@
package tscd_pkg;

   localparam logic [7:0]  CRC_POLY       = 8'h8C;
   localparam logic [3:0]  FRAME_LAST     = 4'd8;
   localparam logic [3:0]  BLANK_LAST     = 4'd7;
   localparam logic [3:0]  RAW_LOW_IDX    = 4'd0;
   localparam logic [3:0]  RAW_HIGH_IDX   = 4'd1;
   localparam logic [7:0]  BYTE_ZERO      = 8'h00;
   localparam logic [7:0]  BYTE_ONES      = 8'hFF;

   localparam logic signed [11:0] TEMP_NA        = 12'sh800;
   localparam logic signed [11:0] LIMIT_LOW_RST  = -12'sd880;
   localparam logic signed [11:0] LIMIT_HIGH_RST = 12'sd2000;

   localparam logic [1:0] QUALITY_FULL     = 2'd0;
   localparam logic [1:0] QUALITY_DEGRADED = 2'd1;
   localparam logic [1:0] QUALITY_NA       = 2'd2;

   localparam logic REG_LIMIT_LOW  = 1'b0;
   localparam logic REG_LIMIT_HIGH = 1'b1;

   typedef struct packed {
      logic       last;
      logic       blank;
      logic [7:0] crc;
      logic [7:0] raw_low;
      logic [7:0] raw_high;
   } frame_type;

   function automatic logic [7:0] crc8_byte(input logic [7:0] crc_i, input logic [7:0] data_i);
      logic [7:0] c;
      logic [7:0] d;
      logic       fb;
      c = crc_i;
      d = data_i;
      for (int k = 0; k < 8; k++) begin
         fb = c[0] ^ d[0];
         c  = {1'b0, c[7:1]};
         if (fb) begin
            c = c ^ CRC_POLY;
         end
         d = {1'b0, d[7:1]};
      end
      return c;
   endfunction

endpackage

@@ src/tscd_frame.sv @@
`include "assert_macros.svh"

module tscd_frame (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic [7:0]           data_byte,
   output tscd_pkg::frame_type  frame
);

   logic [3:0] count_ff,    count_in;
   logic [7:0] crc_ff,      crc_in;
   logic [7:0] raw_low_ff,  raw_low_in;
   logic [7:0] raw_high_ff, raw_high_in;
   logic       zero_ff,     zero_in;
   logic       ones_ff,     ones_in;
   logic       last;

   assign last = (count_ff == tscd_pkg::FRAME_LAST);

   always_comb begin
      count_in    = count_ff;
      crc_in      = crc_ff;
      raw_low_in  = raw_low_ff;
      raw_high_in = raw_high_ff;
      zero_in     = zero_ff;
      ones_in     = ones_ff;
      if (advance) begin
         if (last) begin
            count_in    = '0;
            crc_in      = '0;
            raw_low_in  = '0;
            raw_high_in = '0;
            zero_in     = 1'b1;
            ones_in     = 1'b1;
         end else begin
            count_in = count_ff + 4'd1;
            crc_in   = tscd_pkg::crc8_byte(crc_ff, data_byte);
            if (count_ff == tscd_pkg::RAW_LOW_IDX) begin
               raw_low_in = data_byte;
            end
            if (count_ff == tscd_pkg::RAW_HIGH_IDX) begin
               raw_high_in = data_byte;
            end
            if (count_ff < tscd_pkg::BLANK_LAST) begin
               if (data_byte != tscd_pkg::BYTE_ZERO) begin
                  zero_in = 1'b0;
               end
               if (data_byte != tscd_pkg::BYTE_ONES) begin
                  ones_in = 1'b0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         crc_ff      <= '0;
         raw_low_ff  <= '0;
         raw_high_ff <= '0;
         zero_ff     <= 1'b1;
         ones_ff     <= 1'b1;
      end else begin
         count_ff    <= count_in;
         crc_ff      <= crc_in;
         raw_low_ff  <= raw_low_in;
         raw_high_ff <= raw_high_in;
         zero_ff     <= zero_in;
         ones_ff     <= ones_in;
      end
   end

   assign frame.last     = last;
   assign frame.blank    = zero_ff | ones_ff;
   assign frame.crc      = crc_ff;
   assign frame.raw_low  = raw_low_ff;
   assign frame.raw_high = raw_high_ff;

   `ASSERT_NEVER(a_count_range, clock, reset, count_ff > tscd_pkg::FRAME_LAST, "byte count past frame end")
   `ASSERT_PROP(a_frame_restart, clock, reset, (advance && last) |=> (count_ff == 4'd0 && zero_ff && ones_ff), "frame not restarted after last byte")

endmodule

@@ src/tscd_decode.sv @@
`include "assert_macros.svh"

module tscd_decode (
   input  logic                 clock,
   input  logic                 reset,
   input  tscd_pkg::frame_type  frame,
   input  logic [7:0]           crc_byte,
   input  logic signed [11:0]   limit_low,
   input  logic signed [11:0]   limit_high,
   output logic signed [11:0]   temperature,
   output logic [1:0]           quality
);

   logic               negative;
   logic signed [11:0] value;
   logic               out_of_limits;

   // bit 11 ignored, sign from bits 15..12
   assign negative      = |frame.raw_high[7:4];
   assign value         = {negative, frame.raw_high[2:0], frame.raw_low};
   assign out_of_limits = (value < limit_low) || (value > limit_high);

   always_comb begin
      if (frame.blank || (frame.crc != crc_byte)) begin
         temperature = tscd_pkg::TEMP_NA;
         quality     = tscd_pkg::QUALITY_NA;
      end else begin
         temperature = value;
         quality     = out_of_limits ? tscd_pkg::QUALITY_DEGRADED : tscd_pkg::QUALITY_FULL;
      end
   end

   `ASSERT_NEVER(a_quality_code, clock, reset, quality == 2'd3, "undefined quality code")
   `ASSERT_PROP(a_na_temp, clock, reset, (quality == tscd_pkg::QUALITY_NA) |-> (temperature == tscd_pkg::TEMP_NA), "unavailable result without marker temperature")

endmodule

@@ src/temp_scratchpad_check_decode_core.sv @@
// channel   direction  payload                               handshake
// req_      in         data_byte[7:0]                        req_valid / req_ready
// rsp_      out        temperature[11:0] s, quality[1:0]     rsp_valid / rsp_ready
// csr_      in/out     limit_low @0x0, limit_high @0x4       apb, pready tied high
//
// one byte per cycle while the ninth byte is not held; a byte sits in the input register
// and is folded into the frame state (crc, raw word, blank flags) in one pass
// the ninth byte of a frame goes from the input register into the result register
// only the ninth byte waits on a full, stalled result register; other bytes wait only behind it
// reset is synchronous: frame state cleared, limits back to -880 and 2000
`include "assert_macros.svh"

module temp_scratchpad_check_decode_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_data_byte,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [11:0]  rsp_temperature,
   output logic [1:0]          rsp_quality,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [2:0]          csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready
);

   logic               in_valid_ff,   in_valid_in;
   logic [7:0]         in_byte_ff,    in_byte_in;
   logic               rsp_valid_ff,  rsp_valid_in;
   logic signed [11:0] rsp_temp_ff,   rsp_temp_in;
   logic [1:0]         rsp_qual_ff,   rsp_qual_in;
   logic signed [11:0] limit_low_ff,  limit_low_in;
   logic signed [11:0] limit_high_ff, limit_high_in;

   tscd_pkg::frame_type frame;
   logic                advance;
   logic                load;
   logic                csr_write;
   logic signed [11:0]  dec_temp;
   logic [1:0]          dec_qual;
   logic [11:0]         read_value;

   assign advance   = in_valid_ff && (!frame.last || !rsp_valid_ff || rsp_ready);
   assign load      = advance && frame.last;
   assign req_ready = !in_valid_ff || advance;

   tscd_frame u_frame (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .data_byte (in_byte_ff),
      .frame     (frame)
   );

   tscd_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .frame       (frame),
      .crc_byte    (in_byte_ff),
      .limit_low   (limit_low_ff),
      .limit_high  (limit_high_ff),
      .temperature (dec_temp),
      .quality     (dec_qual)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_data_byte;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_temp_in  = rsp_temp_ff;
      rsp_qual_in  = rsp_qual_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_temp_in  = dec_temp;
         rsp_qual_in  = dec_qual;
      end
   end

   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      limit_low_in  = limit_low_ff;
      limit_high_in = limit_high_ff;
      if (csr_write) begin
         case (csr_paddr[2])
            tscd_pkg::REG_LIMIT_LOW:  limit_low_in  = csr_pwdata[11:0];
            tscd_pkg::REG_LIMIT_HIGH: limit_high_in = csr_pwdata[11:0];
            default: begin
               limit_low_in = limit_low_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         tscd_pkg::REG_LIMIT_LOW:  read_value = limit_low_ff;
         tscd_pkg::REG_LIMIT_HIGH: read_value = limit_high_ff;
         default:                  read_value = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         limit_low_ff  <= tscd_pkg::LIMIT_LOW_RST;
         limit_high_ff <= tscd_pkg::LIMIT_HIGH_RST;
      end else begin
         in_valid_ff   <= in_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         limit_low_ff  <= limit_low_in;
         limit_high_ff <= limit_high_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff  <= in_byte_in;
      rsp_temp_ff <= rsp_temp_in;
      rsp_qual_ff <= rsp_qual_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_temperature = rsp_temp_ff;
   assign rsp_quality     = rsp_qual_ff;
   assign csr_prdata      = {20'd0, read_value};
   assign csr_pready      = 1'b1;

   `ASSERT_PROP(a_result_source, clock, reset, $rose(rsp_valid_ff) |-> $past(load), "result without a closed frame")

endmodule

@@ tb/tscd_reading_check.sv @@
package tscd_tb_pkg;
   import tscd_pkg::*;

   // one scratchpad byte through the reflected crc-8, lsb first
   function automatic logic [7:0] scratchpad_crc_step(input logic [7:0] crc_in,
                                                      input logic [7:0] data);
      logic [7:0] crc;
      crc = crc_in;
      for (int i = 0; i < 8; i++) begin
         if (crc[0] ^ data[i]) begin
            crc = (crc >> 1) ^ CRC_POLY;
         end else begin
            crc = crc >> 1;
         end
      end
      return crc;
   endfunction

endpackage

module tscd_reading_check
   import tscd_pkg::*;
   import tscd_tb_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [7:0]         req_data_byte,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic signed [11:0] rsp_temperature,
   input  logic [1:0]         rsp_quality,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [2:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   input  logic [31:0]        csr_prdata,
   input  logic               csr_pready,
   output int                 fail_count,
   output int                 pending_count,
   output int                 reading_count
);

   typedef struct packed {
      logic signed [11:0] temperature;
      logic [1:0]         quality;
   } reading_t;

   reading_t expected_readings[$];

   logic signed [11:0] lim_lo;
   logic signed [11:0] lim_hi;
   logic [3:0]         frame_pos;
   logic [7:0]         crc_acc;
   logic [7:0]         raw_lo;
   logic [7:0]         raw_hi;
   logic               zero_run;
   logic               ones_run;

   initial begin
      fail_count    = 0;
      pending_count = 0;
      reading_count = 0;
   end

   task automatic clear_frame();
      frame_pos = '0;
      crc_acc   = '0;
      raw_lo    = '0;
      raw_hi    = '0;
      zero_run  = 1'b1;
      ones_run  = 1'b1;
   endtask

   function automatic reading_t decode_frame(input logic [7:0] crc_byte);
      reading_t           r;
      logic [15:0]        word;
      logic signed [11:0] t;
      word = {raw_hi, raw_lo};
      if (zero_run || ones_run || crc_acc != crc_byte) begin
         r.temperature = TEMP_NA;
         r.quality     = QUALITY_NA;
      end else begin
         // sign from bits 15..12, bit 11 dropped
         t = {|word[15:12], word[10:0]};
         r.temperature = t;
         r.quality     = (t < lim_lo || t > lim_hi) ? QUALITY_DEGRADED : QUALITY_FULL;
      end
      return r;
   endfunction

   task automatic take_byte(input logic [7:0] b);
      if (frame_pos < FRAME_LAST) begin
         crc_acc = scratchpad_crc_step(crc_acc, b);
         if (frame_pos == RAW_LOW_IDX) begin
            raw_lo = b;
         end
         if (frame_pos == RAW_HIGH_IDX) begin
            raw_hi = b;
         end
         if (frame_pos < BLANK_LAST) begin
            if (b != BYTE_ZERO) begin
               zero_run = 1'b0;
            end
            if (b != BYTE_ONES) begin
               ones_run = 1'b0;
            end
         end
         frame_pos = frame_pos + 4'd1;
      end else begin
         expected_readings.push_back(decode_frame(b));
         clear_frame();
      end
   endtask

   always @(posedge clock) begin
      reading_t exp_r;
      logic [11:0] reg_val;
      if (reset) begin
         lim_lo = LIMIT_LOW_RST;
         lim_hi = LIMIT_HIGH_RST;
         clear_frame();
         expected_readings.delete();
      end else begin
         // register write transaction
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[2] == REG_LIMIT_LOW) begin
               lim_lo = csr_pwdata[11:0];
            end else begin
               lim_hi = csr_pwdata[11:0];
            end
         end
         // register read transaction
         if (csr_psel && csr_penable && !csr_pwrite && csr_pready) begin
            reg_val = (csr_paddr[2] == REG_LIMIT_LOW) ? lim_lo : lim_hi;
            if (csr_prdata[11:0] !== reg_val) begin
               $error("csr_prdata mismatch at %0h: expected %0h actual %0h",
                      csr_paddr, reg_val, csr_prdata[11:0]);
               fail_count++;
            end
         end
         if (rsp_valid && rsp_ready) begin
            reading_count++;
            if (expected_readings.size() == 0) begin
               $error("rsp transaction with no reading expected: temperature %0d quality %0d",
                      rsp_temperature, rsp_quality);
               fail_count++;
            end else begin
               exp_r = expected_readings.pop_front();
               if (rsp_temperature !== exp_r.temperature) begin
                  $error("temperature mismatch: expected %0d actual %0d",
                         exp_r.temperature, rsp_temperature);
                  fail_count++;
               end
               if (rsp_quality !== exp_r.quality) begin
                  $error("quality mismatch: expected %0d actual %0d",
                         exp_r.quality, rsp_quality);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            take_byte(req_data_byte);
         end
      end
      pending_count <= expected_readings.size();
   end

endmodule

@@ tb/temp_scratchpad_check_decode_core_tb.sv @@
module temp_scratchpad_check_decode_core_tb;
   import tscd_pkg::*;
   import tscd_tb_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 8;
   localparam int NUM_PHASES   = 10;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [7:0]         req_data_byte = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [11:0] rsp_temperature;
   logic [1:0]         rsp_quality;
   logic               csr_psel = 1'b0;
   logic               csr_penable = 1'b0;
   logic               csr_pwrite = 1'b0;
   logic [2:0]         csr_paddr = '0;
   logic [31:0]        csr_pwdata = '0;
   logic [31:0]        csr_prdata;
   logic               csr_pready;

   int fail_count;
   int pending_count;
   int reading_count;

   logic [7:0] byte_q[$];
   int         burst_left = 0;
   bit         gapless = 1'b0;
   int         bytes_sent = 0;
   int         cur_lo = -880;
   int         cur_hi = 2000;

   always #5 clock = ~clock;

   temp_scratchpad_check_decode_core u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_byte   (req_data_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_temperature (rsp_temperature),
      .rsp_quality     (rsp_quality),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   tscd_reading_check u_reading_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_byte   (req_data_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_temperature (rsp_temperature),
      .rsp_quality     (rsp_quality),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready),
      .fail_count      (fail_count),
      .pending_count   (pending_count),
      .reading_count   (reading_count)
   );

   // body holds bytes 0..7, byte i at bits 8i+7..8i; byte 8 is the crc xor flip
   task automatic queue_frame(input logic [63:0] body, input logic [7:0] crc_flip);
      logic [7:0] crc;
      crc = '0;
      for (int i = 0; i < 8; i++) begin
         crc = scratchpad_crc_step(crc, body[8*i +: 8]);
         byte_q.push_back(body[8*i +: 8]);
      end
      byte_q.push_back(crc ^ crc_flip);
   endtask

   function automatic logic [15:0] word_for(input int t);
      logic [11:0] t12;
      logic [31:0] r;
      logic [3:0]  nib;
      t12 = t[11:0];
      r   = $urandom;
      nib = (t < 0) ? ((r[3:0] == 4'h0) ? 4'hF : r[3:0]) : 4'h0;
      return {nib, r[4], t12[10:0]};
   endfunction

   function automatic int clamp_temp(input int t);
      return (t < -2048) ? -2048 : ((t > 2047) ? 2047 : t);
   endfunction

   task automatic queue_random_frame();
      logic [63:0] body;
      logic [7:0]  flip;
      int          kind;
      int          t;
      body = {$urandom, $urandom};
      flip = '0;
      kind = $urandom_range(0, 99);
      case ($urandom_range(0, 5))
         0: t = cur_lo + $urandom_range(0, 4) - 2;
         1: t = cur_hi + $urandom_range(0, 4) - 2;
         2: t = $urandom_range(0, 1) ? -2048 : 2047;
         3: t = $urandom_range(0, 200) - 100;
         default: t = $urandom_range(0, 4095) - 2048;
      endcase
      body[15:0] = word_for(clamp_temp(t));
      if (kind < 8) begin
         body[55:0] = '0;
         flip = $urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(0, 255));
      end else if (kind < 16) begin
         body[55:0] = '1;
         flip = $urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(0, 255));
      end else if (kind < 26) begin
         flip = 8'($urandom_range(1, 255));
      end else if (kind < 34) begin
         body = {$urandom, $urandom};
         flip = 8'($urandom_range(0, 255));
      end else if (kind < 40) begin
         body[15:0] = 16'($urandom);
      end
      queue_frame(body, flip);
   endtask

   task automatic send_byte(input logic [7:0] b);
      int gap;
      if (!gapless && burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      if (burst_left > 0) begin
         burst_left--;
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_queued(input int n);
      repeat (n) begin
         send_byte(byte_q.pop_front());
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(input logic write, input logic addr_sel, input logic [11:0] val);
      logic [31:0] r;
      r = $urandom;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= {addr_sel, 2'b00};
      csr_pwdata  <= {r[31:12], val};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_limits(input int lo, input int hi);
      csr_access(1'b1, REG_LIMIT_LOW, lo[11:0]);
      csr_access(1'b1, REG_LIMIT_HIGH, hi[11:0]);
      csr_access(1'b0, REG_LIMIT_LOW, '0);
      csr_access(1'b0, REG_LIMIT_HIGH, '0);
      cur_lo = lo;
      cur_hi = hi;
   endtask

   // receiver stall pattern, switches mode at random
   initial begin : rsp_stall_pattern
      int mode;
      int span;
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(5, 60);
         repeat (span) begin
            @(posedge clock);
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= 1'($urandom_range(0, 1));
               2: rsp_ready <= ($urandom_range(0, 4) != 0);
               default: rsp_ready <= ($urandom_range(0, 11) == 0);
            endcase
         end
      end
   end

   initial begin : watchdog
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("timeout after %0d cycles", CYCLE_LIMIT);
      $display("Test completed with failures");
      $finish;
   end

   initial begin : stimulus
      int lo;
      int hi;
      int tmp;
      int n;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed frames under the reset limits
      queue_frame(64'h0, 8'h00);                          // blank, all zero
      queue_frame(64'h5A_FF_FF_FF_FF_FF_FF_FF, 8'h00);    // blank, all ones
      queue_frame(64'h10_0C_FF_7F_46_4B_01_91, 8'h00);    // plain reading
      queue_frame(64'h10_0C_FF_7F_46_4B_01_91, 8'h01);    // crc mismatch
      queue_frame(64'hFF_00_FF_7F_46_4B_0F_FF, 8'h00);    // bit eleven set, top of range
      queue_frame(64'h00_FF_FF_7F_46_4B_F8_00, 8'h00);    // most negative
      gapless = 1'b1;
      send_queued(byte_q.size());
      drain();

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase)
            0: begin lo = -2048; hi = 2047; end
            1: begin lo = 2047; hi = -2048; end
            2: begin lo = 0; hi = 0; end
            3: begin lo = -2048; hi = -2048; end
            4: begin lo = 2047; hi = 2047; end
            default: begin
               lo = $urandom_range(0, 4095) - 2048;
               hi = $urandom_range(0, 4095) - 2048;
               if (lo > hi && $urandom_range(0, 3) != 0) begin
                  tmp = lo;
                  lo  = hi;
                  hi  = tmp;
               end
            end
         endcase
         set_limits(lo, hi);
         gapless    = (phase == 2) || ($urandom_range(0, 4) == 0);
         burst_left = 0;
         // leftover bytes straddle phases, so limits also change mid-frame
         n = $urandom_range(45, 85);
         while (byte_q.size() < n) queue_random_frame();
         send_queued(n);
         drain();
      end

      repeat (20) @(posedge clock);
      $display("sent %0d scratchpad bytes over %0d limit settings, %0d readings checked",
               bytes_sent, NUM_PHASES + 1, reading_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
